// File: design/sfv_pkg.sv
package sfv_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W      = 32;
  localparam int DM_W      = IN_W + 1;
  localparam int SQ_W      = 2 * DM_W;
  localparam int LEN_W     = DM_W;
  localparam int K_W       = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int M_W       = LEN_W + 1;
  localparam int PROD_W    = K_W + LEN_W;
  localparam int TEN_W     = PROD_W - FRAC_BITS;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int FM_W      = TEN_W + Q_W - FRAC_BITS;
  localparam int REM_W     = DM_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_K      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REST   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BUNGEE = CFG_IDX_W'(2);

  localparam logic [K_W-1:0] ONE_FIX = K_W'(1) << FRAC_BITS;

  typedef logic [DM_W-1:0]       mag_t;
  typedef mag_t [2:0]            mag3_t;
  typedef logic [Q_W-1:0]        quot_t;
  typedef quot_t [2:0]           quot3_t;

  typedef struct packed {
    logic [2:0] pos;
    logic [2:0] negd;
    mag3_t      dm;
  } sqrt_side_t;

  typedef struct packed {
    logic [TEN_W-1:0] tension;
    logic [2:0]       neg;
    logic             applied;
  } div_side_t;

endpackage

// File: design/sfv_sqrt.sv
module sfv_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [sfv_pkg::SQ_W-1:0]  radicand,
  input  sfv_pkg::sqrt_side_t       in_side,
  output logic                      out_valid,
  output logic [sfv_pkg::LEN_W-1:0] root,
  output sfv_pkg::sqrt_side_t       out_side
);
  import sfv_pkg::*;

  localparam int N = LEN_W;

  logic [SQ_W-1:0] x   [1:N];
  logic [SQ_W-1:0] res [1:N];
  logic            vld [1:N];
  sqrt_side_t      sd  [1:N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (2 * (N - 1 - s));
    logic [SQ_W-1:0] cx, cr, trial;
    logic            cv;
    sqrt_side_t      cs;

    if (s == 0) begin : g_first
      assign cx = radicand;
      assign cr = '0;
      assign cv = in_valid;
      assign cs = in_side;
    end else begin : g_rest
      assign cx = x[s];
      assign cr = res[s];
      assign cv = vld[s];
      assign cs = sd[s];
    end

    assign trial = cr + ONE;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[s+1] <= cs;
        if (cx >= trial) begin
          x[s+1]   <= cx - trial;
          res[s+1] <= (cr >> 1) + ONE;
        end else begin
          x[s+1]   <= cx;
          res[s+1] <= cr >> 1;
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N][LEN_W-1:0];
  assign out_side  = sd[N];

endmodule

// File: design/sfv_div.sv
module sfv_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [sfv_pkg::LEN_W-1:0] len,
  input  sfv_pkg::mag3_t            dm,
  input  sfv_pkg::div_side_t        in_side,
  output logic                      out_valid,
  output sfv_pkg::quot3_t           quot,
  output sfv_pkg::div_side_t        out_side
);
  import sfv_pkg::*;

  localparam int N = Q_W;

  logic [REM_W-1:0] rem [1:N][3];
  quot_t            qt  [1:N][3];
  logic [LEN_W-1:0] ln  [1:N];
  logic             vld [1:N];
  div_side_t        sd  [1:N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [LEN_W-1:0] cl;
    logic             cv;
    div_side_t        cs;

    if (j == 0) begin : g_first
      assign cl = len;
      assign cv = in_valid;
      assign cs = in_side;
    end else begin : g_rest
      assign cl = ln[j];
      assign cv = vld[j];
      assign cs = sd[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ln[j+1] <= cl;
        sd[j+1] <= cs;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [REM_W-1:0] t;
      quot_t            pq;
      logic             ge;

      if (j == 0) begin : g_first
        assign t  = {1'b0, dm[l]};
        assign pq = '0;
      end else begin : g_rest
        assign t  = {rem[j][l][REM_W-2:0], 1'b0};
        assign pq = qt[j][l];
      end

      assign ge = t >= {1'b0, cl};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1][l] <= ge ? t - {1'b0, cl} : t;
          qt[j+1][l]  <= {pq[Q_W-2:0], ge};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_side  = sd[N];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quot[l] = qt[N][l];
  end

endmodule

// File: design/spring_force_vector.sv
// channel | handshake            | payload
// --------+----------------------+--------------------------------------------
// in      | in_valid / in_stall  | particle_x/y/z, end_x/y/z
// out     | out_valid / out_stall| force_x/y/z, force_applied, saturated
// cfg     | cfg_we               | cfg_index, cfg_data
//
// One item per cycle while out_stall does not freeze the pipeline. The path runs
// through the 33-stage square root and the FRAC_BITS+1 stage divider (Q16.16).
// Reset clears all valid bits and loads the register defaults.
// out_stall with a waiting result freezes every stage; in_stall follows it.
module spring_force_vector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            particle_x,
  input  logic signed [31:0]            particle_y,
  input  logic signed [31:0]            particle_z,
  input  logic signed [31:0]            end_x,
  input  logic signed [31:0]            end_y,
  input  logic signed [31:0]            end_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            force_x,
  output logic signed [31:0]            force_y,
  output logic signed [31:0]            force_z,
  output logic                          force_applied,
  output logic                          saturated,
  input  logic                          cfg_we,
  input  logic [sfv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfv_pkg::CFG_W-1:0]     cfg_data
);
  import sfv_pkg::*;

  localparam int FP_W = TEN_W + Q_W;

  logic [K_W-1:0]   spring_constant;
  logic [K_W-1:0]   rest_length;
  logic             bungee_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_constant <= ONE_FIX;
      rest_length     <= ONE_FIX;
      bungee_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_K:      spring_constant <= cfg_data[K_W-1:0];
        REG_REST:   rest_length     <= cfg_data[K_W-1:0];
        REG_BUNGEE: bungee_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // difference
  logic [IN_W-1:0] pin [3];
  logic [IN_W-1:0] ein [3];
  assign pin[0] = particle_x;
  assign pin[1] = particle_y;
  assign pin[2] = particle_z;
  assign ein[0] = end_x;
  assign ein[1] = end_y;
  assign ein[2] = end_z;

  sqrt_side_t s1_side_next;
  for (genvar i = 0; i < 3; i++) begin : g_diff
    logic [DM_W-1:0] d;
    assign d = {pin[i][IN_W-1], pin[i]} - {ein[i][IN_W-1], ein[i]};
    assign s1_side_next.pos[i]  = !d[DM_W-1] && (d != '0);
    assign s1_side_next.negd[i] = d[DM_W-1];
    assign s1_side_next.dm[i]   = d[DM_W-1] ? -d : d;
  end

  logic       s1_vld, s2_vld, s3_vld;
  sqrt_side_t s1_side, s2_side, s3_side;
  logic [SQ_W-1:0] s2_sq [3];
  logic [SQ_W-1:0] s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= s1_side_next;
      s2_side <= s1_side;
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= s1_side.dm[i] * s1_side.dm[i];
      end
      s3_side <= s2_side;
      s3_sum  <= s2_sq[0] + s2_sq[1] + s2_sq[2];
    end
  end

  logic             sq_vld;
  logic [LEN_W-1:0] sq_root;
  sqrt_side_t       sq_side;

  sfv_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_vld),
    .radicand  (s3_sum),
    .in_side   (s3_side),
    .out_valid (sq_vld),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // stretch, flags, direction
  logic [M_W-1:0] m;
  logic           m_pos;
  assign m     = {1'b0, sq_root} - {3'b0, rest_length};
  assign m_pos = !m[M_W-1] && (m != '0);

  logic             s4_vld;
  logic [LEN_W-1:0] s4_len, s4_mmag;
  mag3_t            s4_dm;
  logic [2:0]       s4_neg;
  logic             s4_app;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_len  <= sq_root;
      s4_mmag <= m[M_W-1] ? LEN_W'(-m) : m[LEN_W-1:0];
      s4_dm   <= sq_side.dm;
      s4_neg  <= ({3{m_pos}} & sq_side.pos) | ({3{m[M_W-1]}} & sq_side.negd);
      s4_app  <= !(bungee_mode && m[M_W-1]) && (sq_root != '0);
    end
  end

  // tension
  logic [PROD_W-1:0] ten_prod;
  assign ten_prod = s4_mmag * spring_constant;

  logic             s5_vld;
  logic [LEN_W-1:0] s5_len;
  mag3_t            s5_dm;
  div_side_t        s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_len          <= s4_len;
      s5_dm           <= s4_dm;
      s5_side.tension <= ten_prod[PROD_W-1:FRAC_BITS];
      s5_side.neg     <= s4_neg;
      s5_side.applied <= s4_app;
    end
  end

  logic      dv_vld;
  quot3_t    dv_q;
  div_side_t dv_side;

  sfv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_vld),
    .len       (s5_len),
    .dm        (s5_dm),
    .in_side   (s5_side),
    .out_valid (dv_vld),
    .quot      (dv_q),
    .out_side  (dv_side)
  );

  // component magnitudes
  logic            s6_vld;
  logic [FM_W-1:0] s6_fm [3];
  div_side_t       s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side <= dv_side;
      for (int i = 0; i < 3; i++) begin
        s6_fm[i] <= FM_W'((FP_W'(dv_side.tension) * FP_W'(dv_q[i])) >> FRAC_BITS);
      end
    end
  end

  // saturation and output register
  localparam logic [FM_W-1:0] POS_MAX = FM_W'(32'h7fff_ffff);
  localparam logic [FM_W-1:0] NEG_MAX = FM_W'(33'h1_0000_0000 >> 1);

  logic [31:0] f_next [3];
  logic [2:0]  clip;

  for (genvar i = 0; i < 3; i++) begin : g_sat
    always_comb begin
      clip[i]   = 1'b0;
      f_next[i] = '0;
      if (s6_side.applied) begin
        if (s6_side.neg[i]) begin
          if (s6_fm[i] > NEG_MAX) begin
            clip[i]   = 1'b1;
            f_next[i] = 32'h8000_0000;
          end else begin
            f_next[i] = -s6_fm[i][31:0];
          end
        end else begin
          if (s6_fm[i] > POS_MAX) begin
            clip[i]   = 1'b1;
            f_next[i] = 32'h7fff_ffff;
          end else begin
            f_next[i] = s6_fm[i][31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x       <= f_next[0];
      force_y       <= f_next[1];
      force_z       <= f_next[2];
      force_applied <= s6_side.applied;
      saturated     <= |clip;
    end
  end

  a_no_force_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !force_applied |-> force_x == 0 && force_y == 0 && force_z == 0)
    else $error("force without force_applied");

  a_sat_applied: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> force_applied)
    else $error("saturated without force");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      force_x == 32'h7fff_ffff || force_x == 32'h8000_0000 ||
      force_y == 32'h7fff_ffff || force_y == 32'h8000_0000 ||
      force_z == 32'h7fff_ffff || force_z == 32'h8000_0000)
    else $error("saturated flag with no clipped component");

endmodule
